// ===== sv/assert_macros.svh =====
// assert_macros.svh
// Concurrent assertion macros shared by the modulation matrix RTL.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MME_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MME_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MME_ASSERT(lbl, clk, rst, prop, msg)
`define MME_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/mme_pkg.sv =====
// mme_pkg.sv
// Field widths, opcodes, the route entry type and the control struct of the
// modulation matrix evaluator. No dependencies.
package mme_pkg;

   localparam int OPCODE_W     = 2;
   localparam int ROUTE_SLOT_W = 5;
   localparam int SRC_FIELD_W  = 4;
   localparam int DEST_FIELD_W = 5;
   localparam int LEVEL_W      = 16;
   localparam int PROD_W       = 2 * LEVEL_W;
   localparam int SUM_W        = 40;
   localparam int FRAC_W       = 15;
   localparam int MASK_W       = 12;

   localparam logic [MASK_W-1:0] MASK_RESET = 12'hA03;

   localparam logic signed [LEVEL_W-1:0] Q15_MAX = 16'sh7FFF;
   localparam logic signed [LEVEL_W-1:0] Q15_MIN = 16'sh8000;

   localparam logic [OPCODE_W-1:0] OP_ROUTE_WR  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SOURCE_WR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_EVALUATE  = 2'd2;

   typedef struct packed {
      logic [SRC_FIELD_W-1:0]    src;
      logic [DEST_FIELD_W-1:0]   dst;
      logic signed [LEVEL_W-1:0] amount;
      logic                      bipolar;
      logic                      enabled;
   } route_type;

   typedef struct packed {
      logic start;
      logic mul_en;
      logic acc_en;
      logic rd_en;
   } acc_ctrl_type;

endpackage

// ===== sv/mme_route_table.sv =====
// mme_route_table.sv
// Route table memory with a registered read port and per-entry enable flags.
// Depends on mme_pkg for the route entry type.
module mme_route_table #(
   parameter int MAX_ROUTES = 32,
   localparam int ROUTE_IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [ROUTE_IDX_W-1:0] wr_slot,
   input  mme_pkg::route_type     wr_data,
   input  logic                   rd_en,
   input  logic [ROUTE_IDX_W-1:0] rd_slot,
   output mme_pkg::route_type     rd_data
);

   mme_pkg::route_type route_mem [MAX_ROUTES];
   mme_pkg::route_type rd_data_ff;
   logic [MAX_ROUTES-1:0] enabled_ff;
   logic rd_enabled_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[wr_slot] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= route_mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= '0;
         rd_enabled_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            enabled_ff[wr_slot] <= wr_data.enabled;
         end
         if (rd_en) begin
            rd_enabled_ff <= enabled_ff[rd_slot];
         end
      end
   end

   always_comb begin
      rd_data         = rd_data_ff;
      rd_data.enabled = rd_enabled_ff;
   end

endmodule

// ===== sv/mme_accum.sv =====
// mme_accum.sv
// Shared multiplier, destination sum memory and Q1.15 saturation of results.
// Depends on mme_pkg for widths and the control struct.
module mme_accum #(
   parameter int NUM_DESTINATIONS = 20,
   localparam int DEST_IDX_W = (NUM_DESTINATIONS > 1) ? $clog2(NUM_DESTINATIONS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mme_pkg::acc_ctrl_type               ctrl,
   input  logic signed [mme_pkg::LEVEL_W-1:0]  op_level,
   input  logic signed [mme_pkg::LEVEL_W-1:0]  op_amount,
   input  logic                                op_valid,
   input  logic [DEST_IDX_W-1:0]               op_dest,
   input  logic [DEST_IDX_W-1:0]               rd_dest,
   output logic signed [mme_pkg::LEVEL_W-1:0]  rd_value
);

   localparam int SUM_W  = mme_pkg::SUM_W;
   localparam int PROD_W = mme_pkg::PROD_W;
   localparam int TOP_LO = mme_pkg::FRAC_W + mme_pkg::LEVEL_W - 1;

   logic signed [SUM_W-1:0] sum_mem [NUM_DESTINATIONS];
   logic [NUM_DESTINATIONS-1:0] touched_ff;
   logic signed [PROD_W-1:0] product_ff;
   logic [DEST_IDX_W-1:0] pdest_ff;
   logic pvalid_ff;
   logic signed [SUM_W-1:0] rd_data_ff;
   logic rd_touched_ff;
   logic rd_any;
   logic [DEST_IDX_W-1:0] rd_addr;
   logic signed [SUM_W-1:0] base_sum;
   logic signed [SUM_W-1:0] acc_sum;
   logic [SUM_W-1:TOP_LO] top_bits;

   assign rd_any   = ctrl.mul_en | ctrl.rd_en;
   assign rd_addr  = ctrl.mul_en ? op_dest : rd_dest;
   assign base_sum = rd_touched_ff ? rd_data_ff : '0;
   assign acc_sum  = base_sum + {{(SUM_W-PROD_W){product_ff[PROD_W-1]}}, product_ff};

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         product_ff <= op_level * op_amount;
         pdest_ff   <= op_dest;
      end
      if (ctrl.acc_en && pvalid_ff) begin
         sum_mem[pdest_ff] <= acc_sum;
      end
      if (rd_any) begin
         rd_data_ff <= sum_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff    <= '0;
         pvalid_ff     <= 1'b0;
         rd_touched_ff <= 1'b0;
      end else begin
         if (ctrl.start) begin
            touched_ff <= '0;
         end else if (ctrl.acc_en && pvalid_ff) begin
            touched_ff[pdest_ff] <= 1'b1;
         end
         if (ctrl.mul_en) begin
            pvalid_ff <= op_valid;
         end
         if (rd_any) begin
            rd_touched_ff <= touched_ff[rd_addr];
         end
      end
   end

   assign top_bits = base_sum[SUM_W-1:TOP_LO];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         rd_value = base_sum[TOP_LO:mme_pkg::FRAC_W];
      end else if (base_sum[SUM_W-1]) begin
         rd_value = mme_pkg::Q15_MIN;
      end else begin
         rd_value = mme_pkg::Q15_MAX;
      end
   end

endmodule

// ===== sv/modulation_matrix_evaluator.sv =====
// An evaluate request occupies the block, with req_stall high, from acceptance until the
// final result is loaded into the result register: every route slot passes through an
// operand step and an accumulate step in the shared multiply-accumulate unit, and each of
// the NUM_DESTINATIONS results needs one read of the destination sum memory. A stalled
// result holds up the next one. Route and source write requests may follow each other
// back to back. Results come out in destination order, the final
// one flagged by rsp_last.
//
// modulation_matrix_evaluator.sv: top level with source registers, mask register,
// sequencer and result register. Depends on mme_pkg, mme_route_table, mme_accum
// and assert_macros.svh.
`include "assert_macros.svh"

module modulation_matrix_evaluator #(
   parameter int MAX_ROUTES       = 32,
   parameter int NUM_SOURCES      = 12,
   parameter int NUM_DESTINATIONS = 20
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [mme_pkg::MASK_W-1:0]              csr_write_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [mme_pkg::OPCODE_W-1:0]            req_opcode,
   input  logic [mme_pkg::ROUTE_SLOT_W-1:0]        req_route_slot,
   input  logic [mme_pkg::SRC_FIELD_W-1:0]         req_route_source,
   input  logic [mme_pkg::DEST_FIELD_W-1:0]        req_route_destination,
   input  logic signed [mme_pkg::LEVEL_W-1:0]      req_route_amount,
   input  logic                                    req_route_bipolar,
   input  logic                                    req_route_enabled,
   input  logic [mme_pkg::SRC_FIELD_W-1:0]         req_source_slot,
   input  logic signed [mme_pkg::LEVEL_W-1:0]      req_source_level,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [mme_pkg::DEST_FIELD_W-1:0]        rsp_dest_index,
   output logic signed [mme_pkg::LEVEL_W-1:0]      rsp_dest_value,
   output logic                                    rsp_last
);

   localparam int ROUTE_IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int SRC_IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int DEST_IDX_W  = (NUM_DESTINATIONS > 1) ? $clog2(NUM_DESTINATIONS) : 1;
   localparam int MASK_EXT_W  = 2 ** mme_pkg::SRC_FIELD_W;
   localparam int LEVEL_W     = mme_pkg::LEVEL_W;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_OPERAND = 2'd1;
   localparam logic [1:0] ST_ACC     = 2'd2;
   localparam logic [1:0] ST_EMIT    = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [ROUTE_IDX_W-1:0] route_idx_ff, route_idx_in;
   logic [DEST_IDX_W-1:0] emit_idx_ff, emit_idx_in;
   logic rd_pending_ff, rd_pending_in;
   logic [mme_pkg::MASK_W-1:0] mask_ff;
   logic signed [LEVEL_W-1:0] source_ff [NUM_SOURCES];
   logic rsp_valid_ff, rsp_valid_in;
   logic [mme_pkg::DEST_FIELD_W-1:0] rsp_index_ff;
   logic signed [LEVEL_W-1:0] rsp_value_ff;
   logic rsp_last_ff;

   logic accept;
   logic rsp_load;
   logic route_last;
   logic emit_last;
   logic route_wr_en;
   logic [ROUTE_IDX_W-1:0] route_wr_slot;
   mme_pkg::route_type route_wr_data;
   logic route_rd_en;
   logic [ROUTE_IDX_W-1:0] route_rd_slot;
   mme_pkg::route_type route_rd_data;
   mme_pkg::acc_ctrl_type acc_ctrl;
   logic [DEST_IDX_W-1:0] op_dest;
   logic [DEST_IDX_W-1:0] rd_dest;
   logic op_valid;
   logic signed [LEVEL_W-1:0] raw_level;
   logic signed [LEVEL_W-1:0] op_level;
   logic signed [LEVEL_W-1:0] rd_value;
   logic src_ok;
   logic dst_ok;
   logic nat_bipolar;
   logic [MASK_EXT_W-1:0] mask_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign route_wr_en   = accept && (req_opcode == mme_pkg::OP_ROUTE_WR) &&
                          (32'(req_route_slot) < MAX_ROUTES);
   assign route_wr_slot = ROUTE_IDX_W'(req_route_slot);
   assign route_wr_data = '{src: req_route_source, dst: req_route_destination,
                            amount: req_route_amount, bipolar: req_route_bipolar,
                            enabled: req_route_enabled};

   mme_route_table #(
      .MAX_ROUTES(MAX_ROUTES)
   ) u_route_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (route_wr_en),
      .wr_slot (route_wr_slot),
      .wr_data (route_wr_data),
      .rd_en   (route_rd_en),
      .rd_slot (route_rd_slot),
      .rd_data (route_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= mme_pkg::MASK_RESET;
      end else if (csr_write_enable) begin
         mask_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            source_ff[i] <= '0;
         end
      end else if (accept && (req_opcode == mme_pkg::OP_SOURCE_WR) &&
                   (32'(req_source_slot) < NUM_SOURCES)) begin
         source_ff[SRC_IDX_W'(req_source_slot)] <= req_source_level;
      end
   end

   // Operand selection for the route whose entry was just read.
   assign mask_ext    = MASK_EXT_W'(mask_ff);
   assign src_ok      = 32'(route_rd_data.src) < NUM_SOURCES;
   assign dst_ok      = 32'(route_rd_data.dst) < NUM_DESTINATIONS;
   assign raw_level   = src_ok ? source_ff[SRC_IDX_W'(route_rd_data.src)] : '0;
   assign nat_bipolar = mask_ext[route_rd_data.src];
   assign op_level    = (nat_bipolar && !route_rd_data.bipolar) ?
                        {1'b0, ~raw_level[LEVEL_W-1], raw_level[LEVEL_W-2:1]} : raw_level;
   assign op_valid    = route_rd_data.enabled && dst_ok;
   assign op_dest     = dst_ok ? DEST_IDX_W'(route_rd_data.dst) : '0;

   mme_accum #(
      .NUM_DESTINATIONS(NUM_DESTINATIONS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (acc_ctrl),
      .op_level  (op_level),
      .op_amount (route_rd_data.amount),
      .op_valid  (op_valid),
      .op_dest   (op_dest),
      .rd_dest   (rd_dest),
      .rd_value  (rd_value)
   );

   assign route_last = (route_idx_ff == ROUTE_IDX_W'(MAX_ROUTES - 1));
   assign emit_last  = (emit_idx_ff == DEST_IDX_W'(NUM_DESTINATIONS - 1));
   assign rsp_load   = (state_ff == ST_EMIT) && rd_pending_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      route_idx_in  = route_idx_ff;
      emit_idx_in   = emit_idx_ff;
      rd_pending_in = rd_pending_ff;
      route_rd_en   = 1'b0;
      route_rd_slot = '0;
      acc_ctrl      = '0;
      rd_dest       = emit_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == mme_pkg::OP_EVALUATE)) begin
               acc_ctrl.start = 1'b1;
               route_rd_en    = 1'b1;
               route_idx_in   = '0;
               state_in       = ST_OPERAND;
            end
         end
         ST_OPERAND: begin
            acc_ctrl.mul_en = 1'b1;
            if (!route_last) begin
               route_rd_en   = 1'b1;
               route_rd_slot = route_idx_ff + ROUTE_IDX_W'(1);
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_ctrl.acc_en = 1'b1;
            if (route_last) begin
               emit_idx_in   = '0;
               rd_pending_in = 1'b0;
               state_in      = ST_EMIT;
            end else begin
               route_idx_in = route_idx_ff + ROUTE_IDX_W'(1);
               state_in     = ST_OPERAND;
            end
         end
         ST_EMIT: begin
            if (!rd_pending_ff) begin
               acc_ctrl.rd_en = 1'b1;
               rd_pending_in  = 1'b1;
            end else if (rsp_load) begin
               if (emit_last) begin
                  rd_pending_in = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  emit_idx_in    = emit_idx_ff + DEST_IDX_W'(1);
                  acc_ctrl.rd_en = 1'b1;
                  rd_dest        = emit_idx_ff + DEST_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         route_idx_ff  <= '0;
         emit_idx_ff   <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         route_idx_ff  <= route_idx_in;
         emit_idx_ff   <= emit_idx_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= mme_pkg::DEST_FIELD_W'(emit_idx_ff);
         rsp_value_ff <= rd_value;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_index = rsp_index_ff;
   assign rsp_dest_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

   `MME_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE) && !rsp_valid_ff, "reset did not return the sequencer to idle")
   `MME_ASSERT(a_acc_after_operand, clock, reset, (state_ff == ST_ACC) |-> $past(state_ff == ST_OPERAND), "accumulate step without an operand step")
   `MME_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) && !$past(reset) |-> $past(state_ff == ST_EMIT), "result raised outside the emit phase")
   `MME_ASSERT(a_emit_done_last, clock, reset, (state_ff == ST_IDLE) && !$past(reset) && $past(state_ff == ST_EMIT) |-> $past(emit_last) && rsp_valid_ff && rsp_last_ff, "emit phase ended before the final destination")
   `MME_ASSERT(a_last_index, clock, reset, rsp_valid_ff && rsp_last_ff |-> rsp_index_ff == mme_pkg::DEST_FIELD_W'(NUM_DESTINATIONS - 1), "last flag on a destination that is not final")

endmodule
